### rtl/lrd_pkg.sv
`default_nettype none
package lrd_pkg;

	localparam int MAX_LAYERS = 16;
	localparam int LW = $clog2(MAX_LAYERS);
	localparam int NW = $clog2(MAX_LAYERS + 1);
	localparam int SUM_W = 32 + LW;
	localparam int NUM_W = 62;
	localparam int DEN_W = 31;

	localparam logic [15:0] COEF_ONE = 16'h8000;
	localparam logic [DEN_W-1:0] K_ONE = 31'h4000_0000;

	// coefficient slots within one layer word
	localparam int SLOT_A = 0;
	localparam int SLOT_R = 1;
	localparam int SLOT_T = 2;
	localparam int SLOT_AB = 3;
	localparam int SLOT_RB = 4;
	localparam int SLOT_TB = 5;

	localparam logic COMMAND_LOAD = 1'b0;
	localparam logic COMMAND_RUN = 1'b1;

	localparam logic [1:0] CFG_LAYER_COUNT = 2'd0;
	localparam logic [1:0] CFG_MAX_PASSES = 2'd1;
	localparam logic [1:0] CFG_TOLERANCE = 2'd2;

	localparam logic [1:0] STAT_CONVERGED = 2'd0;
	localparam logic [1:0] STAT_NOT_CONVERGED = 2'd1;
	localparam logic [1:0] STAT_ZERO_DENOM = 2'd2;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_K,
		MUL_COEF_FLUX,
		MUL_COEF_REFL,
		MUL_PROD_FLUX
	} mul_sel_t;

	typedef struct packed {
		logic [3:0] layer_index;
		logic [15:0] absorb_top;
		logic [15:0] reflect_top;
		logic [15:0] transmit_top;
		logic [15:0] absorb_bottom;
		logic [15:0] reflect_bottom;
		logic [15:0] transmit_bottom;
		logic [31:0] flux_down_in;
		logic [31:0] flux_up_in;
		logic [31:0] absorbed_above_in;
		logic [31:0] absorbed_below_in;
	} load_t;

	typedef struct packed {
		logic load_we;
		logic rd_en;
		logic [LW-1:0] rd_addr;
		logic [LW-1:0] p;
		logic [LW-1:0] q;
		logic [LW-1:0] c;
		logic dir_up;
		logic cap_p;
		logic cap_q;
		mul_sel_t mul_sel;
		logic k_load;
		logic div_start;
		logic [1:0] term;
		logic acc_en;
		logic wb_en;
		logic clr_down;
		logic clr_up;
		logic sum_clr;
		logic sum_add;
		logic [15:0] tolerance;
		logic out_load;
		logic out_last;
		logic [1:0] out_status;
	} cmd_t;

	typedef struct packed {
		logic k_zero;
		logic div_done;
		logic conv;
		logic out_free;
	} sts_t;

	function automatic logic [15:0] clamp_coef(input logic [15:0] v);
		return (v > COEF_ONE) ? COEF_ONE : v;
	endfunction

	function automatic logic [15:0] coef_slot(input logic [95:0] w, input int slot);
		return clamp_coef(w[slot*16 +: 16]);
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage
`default_nettype wire

### rtl/lrd_if.sv
`default_nettype none
interface lrd_req_if;
	logic valid;
	logic ready;
	logic command;
	logic [3:0] layer_index;
	logic [15:0] absorb_top;
	logic [15:0] reflect_top;
	logic [15:0] transmit_top;
	logic [15:0] absorb_bottom;
	logic [15:0] reflect_bottom;
	logic [15:0] transmit_bottom;
	logic [31:0] flux_down_in;
	logic [31:0] flux_up_in;
	logic [31:0] absorbed_above_in;
	logic [31:0] absorbed_below_in;

	modport source (output valid, command, layer_index, absorb_top, reflect_top, transmit_top,
		absorb_bottom, reflect_bottom, transmit_bottom, flux_down_in, flux_up_in,
		absorbed_above_in, absorbed_below_in, input ready);
	modport sink (input valid, command, layer_index, absorb_top, reflect_top, transmit_top,
		absorb_bottom, reflect_bottom, transmit_bottom, flux_down_in, flux_up_in,
		absorbed_above_in, absorbed_below_in, output ready);
endinterface

interface lrd_res_if;
	logic valid;
	logic ready;
	logic [3:0] out_layer;
	logic [31:0] flux_down_left;
	logic [31:0] flux_up_left;
	logic [31:0] absorbed_above;
	logic [31:0] absorbed_below;
	logic [31:0] absorbed_total;
	logic [1:0] status;
	logic last;

	modport source (output valid, out_layer, flux_down_left, flux_up_left, absorbed_above,
		absorbed_below, absorbed_total, status, last, input ready);
	modport sink (input valid, out_layer, flux_down_left, flux_up_left, absorbed_above,
		absorbed_below, absorbed_total, status, last, output ready);
endinterface

interface lrd_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/layered_radiation_distributor.sv
// load request: accepted when idle, no result
// run request: each layer-pair step is paced by one shared 32x32 multiplier and a
// one-bit-per-cycle divider used four times per step; a pass is 2*(n-1) steps plus
// clearing and residual summing
// results: one per layer, paced by the sink's ready
// reset: control cleared, settings 9 layers/20 passes/tolerance 1, layer store undefined
`default_nettype none
module layered_radiation_distributor (
	input wire logic clk,
	input wire logic arst_n,
	lrd_req_if.sink request,
	lrd_res_if.source result,
	lrd_cfg_if.sink cfg
);
	import lrd_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;
	load_t ld;

	// payload of a load request goes straight to the layer store
	assign ld.layer_index = request.layer_index;
	assign ld.absorb_top = request.absorb_top;
	assign ld.reflect_top = request.reflect_top;
	assign ld.transmit_top = request.transmit_top;
	assign ld.absorb_bottom = request.absorb_bottom;
	assign ld.reflect_bottom = request.reflect_bottom;
	assign ld.transmit_bottom = request.transmit_bottom;
	assign ld.flux_down_in = request.flux_down_in;
	assign ld.flux_up_in = request.flux_up_in;
	assign ld.absorbed_above_in = request.absorbed_above_in;
	assign ld.absorbed_below_in = request.absorbed_below_in;

	// sequencer: sweeps, per-term multiply/divide steps, clearing, residual, emission
	lrd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.request(request),
		.cfg(cfg),
		.sts(sts),
		.cmd(cmd)
	);

	// datapath: layer memories, operand registers, multiplier, divider, result register
	lrd_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.ld(ld),
		.sts(sts),
		.result(result)
	);
endmodule
`default_nettype wire

### rtl/lrd_div.sv
`default_nettype none
module lrd_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [lrd_pkg::NUM_W-1:0] num,
	input wire logic [lrd_pkg::DEN_W-1:0] den,
	output logic done,
	output logic [31:0] quo
);
	import lrd_pkg::*;

	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [31:0] quo_q;
	logic [DEN_W:0] trial;
	logic fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[31]};
	assign fits = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// high half not below divisor: quotient overflows 32 bits
				if ({1'b0, num[NUM_W-1:32]} >= den) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if ({1'b0, num[NUM_W-1:32]} >= den) begin
				quo_q <= 32'hFFFF_FFFF;
			end else begin
				rem_q <= {1'b0, num[NUM_W-1:32]};
				quo_q <= num[31:0];
			end
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule
`default_nettype wire

### rtl/lrd_datapath.sv
`default_nettype none
module lrd_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire lrd_pkg::cmd_t cmd,
	input wire lrd_pkg::load_t ld,
	output lrd_pkg::sts_t sts,
	lrd_res_if.source result
);
	import lrd_pkg::*;

	logic [95:0] coef_mem [MAX_LAYERS];
	logic [31:0] down_mem [MAX_LAYERS];
	logic [31:0] up_mem [MAX_LAYERS];
	logic [31:0] above_mem [MAX_LAYERS];
	logic [31:0] below_mem [MAX_LAYERS];

	logic [95:0] coef_rd_q;
	logic [31:0] down_rd_q, up_rd_q, above_rd_q, below_rd_q;

	logic [31:0] f_q;
	logic [15:0] rp_q, rq_q, cp_t_q, cp_a_q, cq_t_q, cq_a_q;
	logic [31:0] res_q [4];
	logic [63:0] prod_q;
	logic [DEN_W-1:0] k_q;
	logic [SUM_W-1:0] sum_q;

	logic [31:0] mul_a, mul_b;
	logic [NUM_W-1:0] div_num;
	logic div_done;
	logic [31:0] div_quo;

	logic ld_ok;
	logic [LW-1:0] ld_addr;
	logic down_we, up_we, above_we, below_we;
	logic [LW-1:0] down_wa, up_wa, above_wa, below_wa;
	logic [31:0] down_wd, up_wd, above_wd, below_wd;

	logic out_valid_q;
	logic [3:0] out_layer_q;
	logic [31:0] out_down_q, out_up_q, out_above_q, out_below_q, out_total_q;
	logic [1:0] out_status_q;
	logic out_last_q;

	assign ld_ok = int'(ld.layer_index) < MAX_LAYERS;
	assign ld_addr = LW'(ld.layer_index);

	// write port selection; load, write-back and clear never overlap
	always_comb begin
		down_we = 1'b0; down_wa = cmd.c; down_wd = '0;
		up_we = 1'b0; up_wa = cmd.c; up_wd = '0;
		above_we = 1'b0; above_wa = cmd.p; above_wd = '0;
		below_we = 1'b0; below_wa = cmd.p; below_wd = '0;
		if (cmd.load_we && ld_ok) begin
			down_we = 1'b1; down_wa = ld_addr; down_wd = ld.flux_down_in;
			up_we = 1'b1; up_wa = ld_addr; up_wd = ld.flux_up_in;
			above_we = 1'b1; above_wa = ld_addr; above_wd = ld.absorbed_above_in;
			below_we = 1'b1; below_wa = ld_addr; below_wd = ld.absorbed_below_in;
		end else if (cmd.wb_en) begin
			down_we = 1'b1; up_we = 1'b1; above_we = 1'b1; below_we = 1'b1;
			if (cmd.dir_up) begin
				up_wa = cmd.q; up_wd = res_q[0];
				below_wa = cmd.q; below_wd = res_q[1];
				down_wa = cmd.p; down_wd = res_q[2];
				above_wa = cmd.p; above_wd = res_q[3];
			end else begin
				down_wa = cmd.q; down_wd = res_q[0];
				above_wa = cmd.q; above_wd = res_q[1];
				up_wa = cmd.p; up_wd = res_q[2];
				below_wa = cmd.p; below_wd = res_q[3];
			end
		end else begin
			down_we = cmd.clr_down;
			up_we = cmd.clr_up;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_we && ld_ok) begin
			coef_mem[ld_addr] <= {ld.transmit_bottom, ld.reflect_bottom, ld.absorb_bottom,
				ld.transmit_top, ld.reflect_top, ld.absorb_top};
		end
		if (down_we) down_mem[down_wa] <= down_wd;
		if (up_we) up_mem[up_wa] <= up_wd;
		if (above_we) above_mem[above_wa] <= above_wd;
		if (below_we) below_mem[below_wa] <= below_wd;
		if (cmd.rd_en) begin
			coef_rd_q <= coef_mem[cmd.rd_addr];
			down_rd_q <= down_mem[cmd.rd_addr];
			up_rd_q <= up_mem[cmd.rd_addr];
			above_rd_q <= above_mem[cmd.rd_addr];
			below_rd_q <= below_mem[cmd.rd_addr];
		end
	end

	// operand capture for the near (p) and far (q) layer
	always_ff @(posedge clk) begin
		if (cmd.cap_p) begin
			f_q <= cmd.dir_up ? up_rd_q : down_rd_q;
			rp_q <= coef_slot(coef_rd_q, cmd.dir_up ? SLOT_R : SLOT_RB);
			cp_t_q <= coef_slot(coef_rd_q, cmd.dir_up ? SLOT_T : SLOT_TB);
			cp_a_q <= coef_slot(coef_rd_q, cmd.dir_up ? SLOT_A : SLOT_AB);
			res_q[2] <= cmd.dir_up ? down_rd_q : up_rd_q;
			res_q[3] <= cmd.dir_up ? above_rd_q : below_rd_q;
		end
		if (cmd.cap_q) begin
			rq_q <= coef_slot(coef_rd_q, cmd.dir_up ? SLOT_RB : SLOT_R);
			cq_t_q <= coef_slot(coef_rd_q, cmd.dir_up ? SLOT_TB : SLOT_T);
			cq_a_q <= coef_slot(coef_rd_q, cmd.dir_up ? SLOT_AB : SLOT_A);
			res_q[0] <= cmd.dir_up ? up_rd_q : down_rd_q;
			res_q[1] <= cmd.dir_up ? below_rd_q : above_rd_q;
		end
		if (cmd.acc_en) begin
			res_q[cmd.term] <= sat_add(res_q[cmd.term], div_quo);
		end
		if (cmd.k_load) begin
			k_q <= K_ONE - prod_q[DEN_W-1:0];
		end
		if (cmd.mul_sel != MUL_NONE) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.sum_add) begin
			sum_q <= sum_q + SUM_W'(down_rd_q);
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_sel)
			MUL_K: begin
				mul_a = {16'd0, rp_q};
				mul_b = {16'd0, rq_q};
			end
			MUL_COEF_FLUX: begin
				mul_a = {16'd0, cmd.term[0] ? cq_a_q : cq_t_q};
				mul_b = f_q;
			end
			MUL_COEF_REFL: begin
				mul_a = {16'd0, cmd.term[0] ? cp_a_q : cp_t_q};
				mul_b = {16'd0, rq_q};
			end
			MUL_PROD_FLUX: begin
				mul_a = prod_q[31:0];
				mul_b = f_q;
			end
			MUL_NONE: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// c*I carries an extra 2^15 to match the Q1.30 denominator
	assign div_num = cmd.term[1] ? prod_q[NUM_W-1:0] : {prod_q[NUM_W-16:0], 15'd0};

	lrd_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num(div_num),
		.den(k_q),
		.done(div_done),
		.quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_layer_q <= 4'(cmd.c);
			out_down_q <= down_rd_q;
			out_up_q <= up_rd_q;
			out_above_q <= above_rd_q;
			out_below_q <= below_rd_q;
			out_total_q <= sat_add(above_rd_q, below_rd_q);
			out_status_q <= cmd.out_status;
			out_last_q <= cmd.out_last;
		end
	end

	assign result.valid = out_valid_q;
	assign result.out_layer = out_layer_q;
	assign result.flux_down_left = out_down_q;
	assign result.flux_up_left = out_up_q;
	assign result.absorbed_above = out_above_q;
	assign result.absorbed_below = out_below_q;
	assign result.absorbed_total = out_total_q;
	assign result.status = out_status_q;
	assign result.last = out_last_q;

	assign sts.k_zero = prod_q[DEN_W-1:0] == K_ONE;
	assign sts.div_done = div_done;
	assign sts.conv = sum_q <= SUM_W'(cmd.tolerance);
	assign sts.out_free = !out_valid_q || result.ready;
endmodule
`default_nettype wire

### rtl/lrd_ctrl.sv
`default_nettype none
module lrd_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	lrd_req_if.sink request,
	lrd_cfg_if.sink cfg,
	input wire lrd_pkg::sts_t sts,
	output lrd_pkg::cmd_t cmd
);
	import lrd_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RD_P,
		S_RD_Q,
		S_CAP_Q,
		S_K_MUL,
		S_K_CHK,
		S_T_MUL_A,
		S_T_MUL_B,
		S_DIV_GO,
		S_DIV_WAIT,
		S_WB,
		S_CLR,
		S_RES,
		S_RES_END,
		S_CHK,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	state_t state_q;
	logic [4:0] layer_count_q;
	logic [5:0] max_passes_q;
	logic [15:0] tolerance_q;
	logic [NW-1:0] n_q;
	logic [5:0] limit_q;
	logic [5:0] pass_q;
	logic err_q;
	logic conv_q;
	logic dir_up_q;
	logic [LW-1:0] p_q;
	logic [LW-1:0] c_q;
	logic [1:0] t_q;

	logic [NW-1:0] n_cfg;
	logic [LW-1:0] last_idx;
	logic [LW-1:0] q_idx;
	logic step_last;
	logic req_fire;
	logic [5:0] pass_next;

	always_comb begin
		if (layer_count_q == '0) begin
			n_cfg = NW'(1);
		end else if (int'(layer_count_q) > MAX_LAYERS) begin
			n_cfg = NW'(MAX_LAYERS);
		end else begin
			n_cfg = NW'(layer_count_q);
		end
	end

	assign last_idx = LW'(n_q - NW'(1));
	assign q_idx = dir_up_q ? p_q - LW'(1) : p_q + LW'(1);
	assign step_last = dir_up_q ? (q_idx == '0) : (q_idx == last_idx);
	assign req_fire = request.valid && request.ready;
	assign pass_next = pass_q + 6'd1;

	assign request.ready = state_q == S_IDLE;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			layer_count_q <= 5'd9;
			max_passes_q <= 6'd20;
			tolerance_q <= 16'd1;
			n_q <= NW'(1);
			limit_q <= 6'd1;
			pass_q <= '0;
			err_q <= 1'b0;
			conv_q <= 1'b0;
			dir_up_q <= 1'b0;
			p_q <= '0;
			c_q <= '0;
			t_q <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_LAYER_COUNT: layer_count_q <= cfg.data[4:0];
					CFG_MAX_PASSES: max_passes_q <= cfg.data[5:0];
					CFG_TOLERANCE: tolerance_q <= cfg.data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire && request.command == COMMAND_RUN) begin
						n_q <= n_cfg;
						limit_q <= (max_passes_q == '0) ? 6'd1 : max_passes_q;
						pass_q <= '0;
						err_q <= 1'b0;
						dir_up_q <= 1'b0;
						p_q <= '0;
						c_q <= '0;
						state_q <= (n_cfg == NW'(1)) ? S_CLR : S_RD_P;
					end
				end
				S_RD_P: state_q <= S_RD_Q;
				S_RD_Q: state_q <= S_CAP_Q;
				S_CAP_Q: state_q <= S_K_MUL;
				S_K_MUL: state_q <= S_K_CHK;
				S_K_CHK: begin
					if (sts.k_zero) begin
						err_q <= 1'b1;
						if (step_last) begin
							c_q <= '0;
							state_q <= S_CLR;
						end else begin
							p_q <= q_idx;
							state_q <= S_RD_P;
						end
					end else begin
						t_q <= '0;
						state_q <= S_T_MUL_A;
					end
				end
				S_T_MUL_A: state_q <= t_q[1] ? S_T_MUL_B : S_DIV_GO;
				S_T_MUL_B: state_q <= S_DIV_GO;
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (sts.div_done) begin
						t_q <= t_q + 2'd1;
						state_q <= (t_q == 2'd3) ? S_WB : S_T_MUL_A;
					end
				end
				S_WB: begin
					if (step_last) begin
						c_q <= '0;
						state_q <= S_CLR;
					end else begin
						p_q <= q_idx;
						state_q <= S_RD_P;
					end
				end
				S_CLR: begin
					if (c_q == last_idx) begin
						c_q <= '0;
						if (!dir_up_q) begin
							dir_up_q <= 1'b1;
							p_q <= last_idx;
							state_q <= (n_q == NW'(1)) ? S_CLR : S_RD_P;
						end else begin
							state_q <= S_RES;
						end
					end else begin
						c_q <= c_q + LW'(1);
					end
				end
				S_RES: begin
					if (c_q == last_idx) begin
						state_q <= S_RES_END;
					end else begin
						c_q <= c_q + LW'(1);
					end
				end
				S_RES_END: state_q <= S_CHK;
				S_CHK: begin
					pass_q <= pass_next;
					conv_q <= sts.conv;
					c_q <= '0;
					if (sts.conv || pass_next >= limit_q) begin
						state_q <= S_EMIT_RD;
					end else begin
						dir_up_q <= 1'b0;
						p_q <= '0;
						state_q <= (n_q == NW'(1)) ? S_CLR : S_RD_P;
					end
				end
				S_EMIT_RD: state_q <= S_EMIT_LD;
				S_EMIT_LD: begin
					if (sts.out_free) begin
						if (c_q == last_idx) begin
							state_q <= S_IDLE;
						end else begin
							c_q <= c_q + LW'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_NONE;
		cmd.p = p_q;
		cmd.q = q_idx;
		cmd.c = c_q;
		cmd.dir_up = dir_up_q;
		cmd.term = t_q;
		cmd.tolerance = tolerance_q;
		cmd.rd_addr = c_q;
		cmd.out_last = c_q == last_idx;
		cmd.out_status = err_q ? STAT_ZERO_DENOM :
			(conv_q ? STAT_CONVERGED : STAT_NOT_CONVERGED);
		unique case (state_q)
			S_IDLE: cmd.load_we = req_fire && request.command == COMMAND_LOAD;
			S_RD_P: begin
				cmd.rd_en = 1'b1;
				cmd.rd_addr = p_q;
			end
			S_RD_Q: begin
				cmd.cap_p = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_addr = q_idx;
			end
			S_CAP_Q: cmd.cap_q = 1'b1;
			S_K_MUL: cmd.mul_sel = MUL_K;
			S_K_CHK: cmd.k_load = 1'b1;
			S_T_MUL_A: cmd.mul_sel = t_q[1] ? MUL_COEF_REFL : MUL_COEF_FLUX;
			S_T_MUL_B: cmd.mul_sel = MUL_PROD_FLUX;
			S_DIV_GO: cmd.div_start = 1'b1;
			S_DIV_WAIT: cmd.acc_en = sts.div_done;
			S_WB: cmd.wb_en = 1'b1;
			S_CLR: begin
				cmd.clr_down = !dir_up_q;
				cmd.clr_up = dir_up_q;
				cmd.sum_clr = 1'b1;
			end
			S_RES: begin
				cmd.rd_en = 1'b1;
				cmd.sum_add = c_q != '0;
			end
			S_RES_END: cmd.sum_add = 1'b1;
			S_CHK: ;
			S_EMIT_RD: cmd.rd_en = 1'b1;
			S_EMIT_LD: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end
endmodule
`default_nettype wire
